>>> rtl/bce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bce_pkg: shared types and constants for binary cross-entropy loss
// Fixed-point widths, log2 table function, FSM state and command structs.
// ---------------------------------------------------------------------------
package bce_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int IN_W        = 17;
    localparam int LOSS_W      = 20;
    localparam int SUM_W       = 40;
    localparam int CNT_W       = 17;
    localparam int MAX_PAIRS   = 65536;
    localparam int TAB_N       = 256;
    localparam int TAB_IW      = 8;
    localparam int MAG_W       = 21;
    localparam int LNV_W       = 21;
    localparam int TERM_W      = 22;
    localparam int DIV_STEPS   = SUM_W;
    localparam int DCNT_W      = 6;
    localparam logic [IN_W-1:0]  ONE_VAL  = IN_W'(1 << FRAC_BITS);
    localparam logic [31:0]      LN2_Q32  = 32'd2977044472;
    localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOGA,
        ST_LOGB,
        ST_SCALE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic sel_b;
        logic log_step;
        logic scale_a;
        logic scale_b;
        logic acc;
        logic div_start;
        logic div_step;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic saturated;
        logic div_done;
    } t_stat;

    // log2(1+k/256) table, Q.16, computed by bitwise squaring
    function automatic logic [FRAC_BITS:0] log_tab(input logic [TAB_IW:0] k);
        logic [63:0] x;
        logic [31:0] frac;
        logic [63:0] r;
        if (k == 9'(TAB_N)) begin
            log_tab = (FRAC_BITS+1)'(1 << FRAC_BITS);
        end else begin
            x = 64'(1) << 31;
            x = x + ((64'(k) << 31) >> TAB_IW);
            frac = '0;
            for (int i = 0; i < 32; i++) begin
                x = (x * x) >> 31;
                frac = frac << 1;
                if (x >= (64'(1) << 32)) begin
                    x = x >> 1;
                    frac[0] = 1'b1;
                end
            end
            r = (64'(frac) + (64'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
            log_tab = r[FRAC_BITS:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/bce_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bce_in_if / bce_out_if: valid-ready request channels
// Input pair channel and loss result channel.
// ---------------------------------------------------------------------------
interface bce_in_if;
    import bce_pkg::*;
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] label;
    logic [IN_W-1:0] prediction;
    logic            last_item;
    modport source (output valid, label, prediction, last_item, input ready);
    modport sink   (input valid, label, prediction, last_item, output ready);
endinterface

interface bce_out_if;
    import bce_pkg::*;
    logic              valid;
    logic              ready;
    logic [LOSS_W-1:0] loss;
    logic              count_overflow;
    modport source (output valid, loss, count_overflow, input ready);
    modport sink   (input valid, loss, count_overflow, output ready);
endinterface
`default_nettype wire

>>> rtl/binary_cross_entropy_loss_top.sv
// Result: a last pair's loss is valid after its two log passes, scaling, accumulate and
// the restoring divide; ordinary pairs give no result.
// The shared log unit is used twice per pair, so a new pair is taken only after the last is accumulated.
// A saturated pair is not accumulated, only flags overflow. Synchronous active-low reset clears sum,
// count and overflow flag.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// binary_cross_entropy_loss_top: streaming BCE loss
// Joins the controller and the datapath to the request channels.
// ---------------------------------------------------------------------------
module binary_cross_entropy_loss_top
    import bce_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    bce_in_if.sink     i_in,
    bce_out_if.source  o_out
);

    t_cmd  cmd;
    t_stat stat;

    bce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_item),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    bce_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_label          (i_in.label),
        .i_prediction     (i_in.prediction),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_loss           (o_out.loss),
        .o_count_overflow (o_out.count_overflow)
    );

endmodule
`default_nettype wire

>>> rtl/bce_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bce_ctrl: sequencing state machine
// Steps each pair through two log passes, accumulate, and the final divide.
// ---------------------------------------------------------------------------
module bce_ctrl
    import bce_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_in_last,
    input  wire   i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_last, n_last;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_last  = i_in_last;
                    n_state = i_stat.saturated ? (i_in_last ? ST_DIV : ST_IDLE) : ST_LOGA;
                end
            end
            ST_LOGA:  n_state = ST_LOGB;
            ST_LOGB:  n_state = ST_SCALE;
            ST_SCALE: n_state = ST_ACC;
            ST_ACC:   n_state = r_last ? ST_DIV : ST_IDLE;
            ST_DIV:   if (i_stat.div_done) n_state = ST_OUT;
            ST_OUT:   if (i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                o_cmd.div_start = i_in_valid & i_stat.saturated & i_in_last;
            end
            ST_LOGA: o_cmd.log_step = 1'b1;
            ST_LOGB: begin
                o_cmd.log_step = 1'b1;
                o_cmd.sel_b    = 1'b1;
                o_cmd.scale_a  = 1'b1;
            end
            ST_SCALE: o_cmd.scale_b = 1'b1;
            ST_ACC: begin
                o_cmd.acc       = 1'b1;
                o_cmd.div_start = r_last;
            end
            ST_DIV: o_cmd.div_step = 1'b1;
            ST_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.clear = i_out_ready;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/bce_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bce_dp: loss datapath
// Clamp, normalizing log unit, term mix, saturating sum, restoring divider.
// ---------------------------------------------------------------------------
module bce_dp
    import bce_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire [IN_W-1:0]   i_label,
    input  wire [IN_W-1:0]   i_prediction,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic [LOSS_W-1:0] o_loss,
    output logic             o_count_overflow
);

    logic [FRAC_BITS:0]   r_y;
    logic [FRAC_BITS-1:0] r_p;
    logic [MAG_W-1:0]     r_mag;
    logic [LNV_W-1:0]     r_lna, r_lnb;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_ovf;
    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W:0]       r_rem;
    logic [CNT_W-1:0]     r_div;
    logic [DCNT_W-1:0]    r_dcnt;
    logic                 r_dbusy;

    // clamp inputs
    logic [FRAC_BITS:0]   y_sat;
    logic [FRAC_BITS-1:0] p_clamp;
    always_comb begin
        y_sat = (i_label > ONE_VAL) ? ONE_VAL : i_label;
        if (i_prediction == '0)            p_clamp = FRAC_BITS'(1);
        else if (i_prediction >= ONE_VAL)  p_clamp = {FRAC_BITS{1'b1}};
        else                               p_clamp = i_prediction[FRAC_BITS-1:0];
    end

    // log2 table, fixed at elaboration
    logic [FRAC_BITS:0] log_rom [TAB_N+1];
    for (genvar k = 0; k <= TAB_N; k++) begin : g_log_rom
        localparam logic [FRAC_BITS:0] ENTRY = log_tab(9'(k));
        assign log_rom[k] = ENTRY;
    end

    // log unit: normalize, table interpolate -> log2 magnitude
    logic [FRAC_BITS-1:0] v, vn;
    logic [4:0]           b;
    logic [TAB_IW-1:0]    idx;
    logic [FRAC_BITS:0]   t0, t1;
    logic [FRAC_BITS-TAB_IW-1:0] rem;
    logic [FRAC_BITS+FRAC_BITS-TAB_IW:0] prod;
    logic [FRAC_BITS:0]   interp;
    logic [MAG_W-1:0]     mag;
    logic [MAG_W+31:0]    lnp;
    always_comb begin
        v = i_cmd.sel_b ? (FRAC_BITS'(0) - r_p) : r_p;
        b = '0;
        for (int i = 0; i < FRAC_BITS; i++)
            if (v[i]) b = 5'(i);
        vn   = v << (5'(FRAC_BITS - 1) - b);
        idx  = vn[FRAC_BITS-2 -: TAB_IW];
        rem  = vn[FRAC_BITS-TAB_IW-2:0] << 1;
        t0   = log_rom[{1'b0, idx}];
        t1   = log_rom[{1'b0, idx} + 9'd1];
        prod = (t1 - t0) * rem;
        interp = t0 + (FRAC_BITS+1)'((prod + (1 << (FRAC_BITS-TAB_IW-1)))
                 >> (FRAC_BITS-TAB_IW));
        mag  = (MAG_W'(5'(FRAC_BITS) - b) << FRAC_BITS) - MAG_W'(interp);
    end

    // scale registered magnitude by ln2, rounded
    always_comb
        lnp = (MAG_W+32)'(r_mag) * (MAG_W+32)'(LN2_Q32)
            + (MAG_W+32)'(64'(1) << 31);

    // term mix
    logic [47:0]       mix;
    logic [TERM_W-1:0] term;
    logic [SUM_W:0]    sum_ext;
    always_comb begin
        mix  = 48'(r_y) * 48'(r_lna) + 48'(ONE_VAL - r_y) * 48'(r_lnb)
             + 48'(1 << (FRAC_BITS-1));
        term = mix[FRAC_BITS +: TERM_W];
        sum_ext = {1'b0, r_sum} + (SUM_W+1)'(term);
    end

    // divider step
    logic [CNT_W+1:0] trial;
    always_comb trial = {r_rem, r_quo[SUM_W-1]} - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_y <= y_sat;
            r_p <= p_clamp;
        end
        if (i_cmd.log_step) r_mag <= mag;
        if (i_cmd.scale_a)  r_lna <= lnp[32 +: LNV_W];
        if (i_cmd.scale_b)  r_lnb <= lnp[32 +: LNV_W];
    end

    // sum, count, divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_sum <= '0; r_cnt <= '0; r_ovf <= 1'b0; r_dbusy <= 1'b0;
        end else begin
            if (i_cmd.load && o_stat.saturated) r_ovf <= 1'b1;
            if (i_cmd.acc) begin
                r_sum <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.div_start) begin
                r_div <= (r_cnt + CNT_W'(i_cmd.acc) == '0) ? CNT_W'(1)
                                                          : r_cnt + CNT_W'(i_cmd.acc);
                r_rem   <= '0;
                r_dcnt  <= '0;
                r_dbusy <= 1'b1;
                r_quo   <= i_cmd.acc ? (sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0])
                                     : r_sum;
            end else if (i_cmd.div_step && r_dbusy) begin
                if (r_dcnt == '0) begin
                    // add half divisor for rounding
                    r_quo  <= r_quo + SUM_W'(r_div >> 1);
                    r_dcnt <= DCNT_W'(1);
                end else begin
                    if (!trial[CNT_W+1]) begin
                        r_rem <= trial[CNT_W:0];
                        r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
                        r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCNT_W'(DIV_STEPS)) r_dbusy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.saturated = (r_cnt == CNT_W'(MAX_PAIRS));
    assign o_stat.div_done  = !r_dbusy;
    assign o_loss = (r_quo > SUM_W'(LOSS_MAX)) ? LOSS_MAX : r_quo[LOSS_W-1:0];
    assign o_count_overflow = r_ovf;

endmodule
`default_nettype wire
